@@ sv/tst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and codes for the topic subscription table.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam int CommandWidth = 2;
   localparam int TopicWidth   = 16;
   localparam int CountWidth   = 5;

   localparam logic [CommandWidth-1:0] CMD_LOOKUP      = 2'd0;
   localparam logic [CommandWidth-1:0] CMD_SUBSCRIBE   = 2'd1;
   localparam logic [CommandWidth-1:0] CMD_UNSUBSCRIBE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_DECIDE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_FINISH
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word, restart index
      logic read_cur;   // read list at index
      logic read_next;  // read list at index + 1
      logic hit;        // record topic as present
      logic step;       // advance index
      logic append;     // write topic at the tail, grow count
      logic move_wr;    // write read data at index
      logic shrink;     // drop one entry from count
      logic lookup_ok;  // result of a lookup follows found
      logic emit;       // load the response register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CommandWidth-1:0] op;
      logic at_end;     // index has reached count
      logic match;      // read data equals topic
      logic last;       // index + 1 has reached count
      logic full;       // no room left
      logic found;
      logic out_busy;   // response register holds an untaken word
   } dp_status_type;

endpackage

@@ sv/tst_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_req_if
// Request channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface tst_req_if;
   logic                               valid;
   logic                               ready;
   logic [tst_pkg::CommandWidth-1:0]   command;
   logic [tst_pkg::TopicWidth-1:0]     topic_tag;

   modport source (output valid, output command, output topic_tag, input ready);
   modport sink   (input valid, input command, input topic_tag, output ready);
endinterface

@@ sv/tst_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_rsp_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface tst_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               found;
   logic                               succeeded;
   logic [tst_pkg::CountWidth-1:0]     entry_count;

   modport source (output valid, output found, output succeeded, output entry_count,
                   input ready);
   modport sink   (input valid, input found, input succeeded, input entry_count,
                   output ready);
endinterface

@@ sv/tst_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_datapath
// List memory, count, walk index and response register.
// ----------------------------------------------------------------------------
module tst_datapath #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [tst_pkg::CommandWidth-1:0]     req_command,
   input  logic [tst_pkg::TopicWidth-1:0]       req_topic_tag,
   input  tst_pkg::dp_cmd_type                  cmd,
   output tst_pkg::dp_status_type               status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic                                 rsp_succeeded,
   output logic [tst_pkg::CountWidth-1:0]       rsp_entry_count
);

   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] DepthValue = CW'(LIST_DEPTH);

   logic [tst_pkg::TopicWidth-1:0]   topic_mem [LIST_DEPTH];
   logic [tst_pkg::TopicWidth-1:0]   rd_data_ff;
   logic [tst_pkg::CommandWidth-1:0] op_ff;
   logic [tst_pkg::TopicWidth-1:0]   topic_ff;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic                             found_ff, found_in;
   logic                             ok_ff, ok_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff;
   logic                             rsp_ok_ff;
   logic [tst_pkg::CountWidth-1:0]   rsp_count_ff;
   logic [CW:0]                      idx_plus;
   logic [CW-1:0]                    rd_pos;
   logic [CW-1:0]                    wr_pos;
   logic [tst_pkg::TopicWidth-1:0]   wr_data;
   logic                             wr_en;
   logic [CW+tst_pkg::CountWidth-1:0] count_wide;

   assign idx_plus   = {1'b0, idx_ff} + (CW+1)'(1);
   assign rd_pos     = cmd.read_next ? idx_plus[CW-1:0] : idx_ff;
   assign wr_en      = cmd.append | cmd.move_wr;
   assign wr_pos     = cmd.append ? count_ff : idx_ff;
   assign wr_data    = cmd.append ? topic_ff : rd_data_ff;
   assign count_wide = {{tst_pkg::CountWidth{1'b0}}, count_ff};

   // list memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         topic_mem[wr_pos[IW-1:0]] <= wr_data;
      end
      if (cmd.read_cur | cmd.read_next) begin
         rd_data_ff <= topic_mem[rd_pos[IW-1:0]];
      end
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
         ok_in    = 1'b0;
      end
      if (cmd.hit) begin
         found_in = 1'b1;
      end
      if (cmd.step) begin
         idx_in = idx_plus[CW-1:0];
      end
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
         ok_in    = 1'b1;
      end
      if (cmd.shrink) begin
         count_in = count_ff - CW'(1);
         ok_in    = 1'b1;
      end
      if (cmd.lookup_ok) begin
         ok_in = found_ff;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_command;
         topic_ff <= req_topic_tag;
      end
      if (cmd.emit) begin
         rsp_found_ff <= found_ff;
         rsp_ok_ff    <= ok_ff;
         rsp_count_ff <= count_wide[tst_pkg::CountWidth-1:0];
      end
   end

   assign status.op       = op_ff;
   assign status.at_end   = (idx_ff == count_ff);
   assign status.match    = (rd_data_ff == topic_ff);
   assign status.last     = (idx_plus >= {1'b0, count_ff});
   assign status.full     = (count_ff == DepthValue);
   assign status.found    = found_ff;
   assign status.out_busy = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_succeeded   = rsp_ok_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

@@ sv/tst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_ctrl
// Sequencer: search the list, then append, close the gap or report.
// ----------------------------------------------------------------------------
module tst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tst_pkg::dp_status_type  status,
   output tst_pkg::dp_cmd_type     cmd
);

   tst_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = tst_pkg::ST_SEARCH;
            end
         end
         tst_pkg::ST_SEARCH: begin
            if (status.at_end) begin
               state_in = tst_pkg::ST_DECIDE;
            end else begin
               cmd.read_cur = 1'b1;
               state_in     = tst_pkg::ST_COMPARE;
            end
         end
         tst_pkg::ST_COMPARE: begin
            if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = tst_pkg::ST_DECIDE;
            end else begin
               cmd.step = 1'b1;
               state_in = tst_pkg::ST_SEARCH;
            end
         end
         tst_pkg::ST_DECIDE: begin
            state_in = tst_pkg::ST_FINISH;
            if (status.op == tst_pkg::CMD_LOOKUP) begin
               cmd.lookup_ok = 1'b1;
            end else if (status.op == tst_pkg::CMD_SUBSCRIBE) begin
               cmd.append = ~status.found & ~status.full;
            end else if (status.op == tst_pkg::CMD_UNSUBSCRIBE && status.found) begin
               state_in = tst_pkg::ST_MOVE_RD;
            end
         end
         tst_pkg::ST_MOVE_RD: begin
            if (status.last) begin
               cmd.shrink = 1'b1;
               state_in   = tst_pkg::ST_FINISH;
            end else begin
               cmd.read_next = 1'b1;
               state_in      = tst_pkg::ST_MOVE_WR;
            end
         end
         tst_pkg::ST_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            cmd.step    = 1'b1;
            state_in    = tst_pkg::ST_MOVE_RD;
         end
         tst_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = tst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tst_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/topic_subscription_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topic_subscription_table_unit
// Compact list of subscribed 16-bit topics with lookup, subscribe and
// unsubscribe.
// ----------------------------------------------------------------------------
// Each request word carries one command and a topic; each gives exactly one
// response word with found, succeeded and the entry count after the command.
// The list sits in a memory with one registered read port and is walked
// entry by entry, a read step then a compare step for each. An unsubscribe
// that removes an entry moves each later entry down to close the gap, then
// drops the count. One request is in flight at a time; the next is taken as
// soon as the previous response word is in the output register, even if it
// has not yet been taken; while that word is still waiting, the following
// request holds in its last step. Unused command code 3 changes nothing and
// reports failure.
// ----------------------------------------------------------------------------
module topic_subscription_table_unit #(
   parameter int LIST_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   tst_req_if.sink    req_chan,
   tst_rsp_if.source  rsp_chan
);

   tst_pkg::dp_cmd_type    dp_cmd;
   tst_pkg::dp_status_type dp_status;

   // sequencer: owns the handshake on the request side
   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // list storage, walk index and response register
   tst_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_chan.command),
      .req_topic_tag   (req_chan.topic_tag),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_found       (rsp_chan.found),
      .rsp_succeeded   (rsp_chan.succeeded),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule
